[src/hcbp_pkg.sv]
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared types and constants for the Huffman code bit packer.
// ----------------------------------------------------------------------------
package hcbp_pkg;

  localparam int SYMBOL_COUNT = 256;
  localparam int MAX_CODE_LEN = 16;
  localparam int VALUE_W      = 16;
  localparam int LEN_W        = 5;
  localparam int SYM_W        = 8;
  localparam int BYTE_W       = 8;
  localparam int PEND_W       = BYTE_W - 1;
  localparam int CNT_W        = 3;
  localparam int LEN_LIMIT    = (MAX_CODE_LEN < VALUE_W) ? MAX_CODE_LEN : VALUE_W;
  localparam int ENTRY_W      = LEN_W + VALUE_W;
  localparam int ACC_W        = PEND_W + VALUE_W;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_ENCODE = 2'd1,
    KIND_FLUSH  = 2'd2
  } kind_t;

  typedef struct packed {
    logic               flush;
    logic [VALUE_W-1:0] code;
    logic [LEN_W-1:0]   len;
  } q_entry_t;

  typedef struct packed {
    logic push;
    logic full;
  } q_wr_ctl_t;

  typedef struct packed {
    logic pop;
    logic empty;
  } q_rd_ctl_t;

endpackage

[src/hcbp_if.sv]
// ----------------------------------------------------------------------------
// hcbp_if
// Valid/ready channels for input items and packed result bytes.
// ----------------------------------------------------------------------------
interface hcbp_item_if import hcbp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [SYM_W-1:0]   symbol;
  logic [VALUE_W-1:0] code_value;
  logic [LEN_W-1:0]   code_length;

  modport source (output valid, kind, symbol, code_value, code_length, input ready);
  modport sink   (input valid, kind, symbol, code_value, code_length, output ready);
endinterface

interface hcbp_result_if import hcbp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last;

  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface

[src/hcbp_front.sv]
// ----------------------------------------------------------------------------
// hcbp_front
// Accepts items, keeps the code table, looks up codes and queues the work.
// ----------------------------------------------------------------------------
module hcbp_front import hcbp_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  hcbp_item_if.sink      item,
  output q_wr_ctl_t      wr_ctl,
  input  logic           q_full,
  output q_entry_t       wr_entry
);

  logic [ENTRY_W-1:0]      table_mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] loaded;

  logic               s1_valid;
  logic               s1_flush;
  logic               rd_hit;
  logic [ENTRY_W-1:0] rd_entry;

  logic               accept;
  logic               s1_free;
  logic               drop;
  logic [LEN_W-1:0]   len_sat;
  logic [VALUE_W:0]   len_mask;
  logic [VALUE_W-1:0] val_masked;
  logic [LEN_W-1:0]   s1_len;

  always_comb begin
    len_sat    = (item.code_length > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT)
                                                         : item.code_length;
    len_mask   = ((VALUE_W+1)'(1) << len_sat) - (VALUE_W+1)'(1);
    val_masked = item.code_value & len_mask[VALUE_W-1:0];
    s1_len     = rd_hit ? rd_entry[ENTRY_W-1:VALUE_W] : '0;
    drop       = !s1_flush && (s1_len == '0);
    s1_free    = !s1_valid || drop || !q_full;
    item.ready = s1_free;
    accept     = item.valid && s1_free;
    wr_ctl.push = s1_valid && !drop && !q_full;
    wr_ctl.full = q_full;
    wr_entry.flush = s1_flush;
    wr_entry.code  = rd_entry[VALUE_W-1:0];
    wr_entry.len   = s1_len;
  end

  always_ff @(posedge clk) begin
    if (accept && item.kind == KIND_LOAD) begin
      table_mem[item.symbol] <= {len_sat, val_masked};
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free) begin
      rd_entry <= table_mem[item.symbol];
      rd_hit   <= loaded[item.symbol];
      s1_flush <= (item.kind == KIND_FLUSH);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      loaded   <= '0;
    end else begin
      if (accept && item.kind == KIND_LOAD) begin
        loaded[item.symbol] <= 1'b1;
      end
      if (s1_free) begin
        s1_valid <= accept && (item.kind == KIND_ENCODE || item.kind == KIND_FLUSH);
      end
    end
  end

endmodule

[src/hcbp_queue.sv]
// ----------------------------------------------------------------------------
// hcbp_queue
// Short FIFO of looked-up codes between the front and the packer.
// ----------------------------------------------------------------------------
module hcbp_queue import hcbp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  q_wr_ctl_t wr_ctl,
  input  q_entry_t  wr_entry,
  output logic      full,
  input  q_rd_ctl_t rd_ctl,
  output q_entry_t  rd_entry,
  output logic      empty
);

  q_entry_t          slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full     = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign rd_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_ctl.push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_ctl.push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (rd_ctl.pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({wr_ctl.push, rd_ctl.pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[src/hcbp_back.sv]
// ----------------------------------------------------------------------------
// hcbp_back
// Packs queued codes into bytes, MSB first, and drives the result channel.
// ----------------------------------------------------------------------------
module hcbp_back import hcbp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  q_entry_t   entry,
  input  logic       q_empty,
  output q_rd_ctl_t  rd_ctl,
  hcbp_result_if.source result
);

  logic              o_valid;
  logic [BYTE_W-1:0] o_byte;
  logic              o_last;
  logic              b2_valid;
  logic [BYTE_W-1:0] b2_byte;
  logic [PEND_W-1:0] pending_bits;
  logic [CNT_W-1:0]  pending_count;

  logic              out_free;
  logic              pop;
  logic [LEN_W-1:0]  total;
  logic [LEN_W-1:0]  sh1;
  logic [LEN_W-1:0]  sh2;
  logic [ACC_W-1:0]  acc;
  logic [BYTE_W-1:0] byte1;
  logic [BYTE_W-1:0] byte2;
  logic [CNT_W-1:0]  rem;
  logic [BYTE_W-1:0] keep_mask;
  logic [PEND_W-1:0] new_pending;
  logic [BYTE_W-1:0] flush_byte;

  always_comb begin
    out_free    = !o_valid || result.ready;
    pop         = !q_empty && !b2_valid && out_free;
    total       = LEN_W'(pending_count) + entry.len;
    sh1         = total - LEN_W'(BYTE_W);
    sh2         = total - LEN_W'(2 * BYTE_W);
    acc         = (ACC_W'(pending_bits) << entry.len) | ACC_W'(entry.code);
    byte1       = BYTE_W'(acc >> sh1);
    byte2       = BYTE_W'(acc >> sh2);
    rem         = total[CNT_W-1:0];
    keep_mask   = (BYTE_W'(1) << rem) - BYTE_W'(1);
    new_pending = acc[PEND_W-1:0] & keep_mask[PEND_W-1:0];
    flush_byte  = BYTE_W'(pending_bits) << (4'(BYTE_W) - 4'(pending_count));
    rd_ctl.pop   = pop;
    rd_ctl.empty = q_empty;
    result.valid    = o_valid;
    result.out_byte = o_byte;
    result.last     = o_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid       <= 1'b0;
      b2_valid      <= 1'b0;
      pending_bits  <= '0;
      pending_count <= '0;
    end else if (out_free) begin
      o_valid <= 1'b0;
      if (b2_valid) begin
        o_valid  <= 1'b1;
        o_byte   <= b2_byte;
        o_last   <= 1'b1;
        b2_valid <= 1'b0;
      end else if (pop) begin
        if (entry.flush) begin
          if (pending_count != '0) begin
            o_valid <= 1'b1;
            o_byte  <= flush_byte;
            o_last  <= 1'b1;
          end
          pending_bits  <= '0;
          pending_count <= '0;
        end else begin
          if (total >= LEN_W'(2 * BYTE_W)) begin
            o_valid  <= 1'b1;
            o_byte   <= byte1;
            o_last   <= 1'b0;
            b2_valid <= 1'b1;
            b2_byte  <= byte2;
          end else if (total >= LEN_W'(BYTE_W)) begin
            o_valid <= 1'b1;
            o_byte  <= byte1;
            o_last  <= 1'b1;
          end
          pending_bits  <= new_pending;
          pending_count <= rem;
        end
      end
    end
  end

endmodule

[src/huffman_code_bit_packer_core.sv]
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_core
// Table-driven Huffman encoder that packs codes into bytes.
// ----------------------------------------------------------------------------
// Channels: item (sink) takes load, encode and flush items; result (source)
// gives packed bytes, earliest bit in bit 7, with last set on the final byte
// an item causes. Both use valid/ready; a transfer happens when both are high.
// A load writes the 256-entry code table and the entry is usable by the
// very next item. An encode appends its code to the pending bits and gives
// zero, one or two bytes; a flush pads the pending bits with zeros.
// Throughput: one item per cycle while the queue has room; an item that gives
// two bytes holds the packer until its second byte enters the single result
// register. An item's first byte is registered at the table read, then in
// a queue slot, then in the result register; stalls can hold it at each.
// Reset clears the table valid bits, pending bits and all control state;
// no clearing pass is needed. When result stalls, the 4-entry queue absorbs
// looked-up items until it fills, then item.ready drops.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer_core import hcbp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  hcbp_item_if.sink     item,
  hcbp_result_if.source result
);

  q_wr_ctl_t wr_ctl;
  q_rd_ctl_t rd_ctl;
  q_entry_t  wr_entry;
  q_entry_t  rd_entry;
  logic      q_full;
  logic      q_empty;

  hcbp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .wr_ctl   (wr_ctl),
    .q_full   (q_full),
    .wr_entry (wr_entry)
  );

  hcbp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_ctl   (wr_ctl),
    .wr_entry (wr_entry),
    .full     (q_full),
    .rd_ctl   (rd_ctl),
    .rd_entry (rd_entry),
    .empty    (q_empty)
  );

  hcbp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .entry   (rd_entry),
    .q_empty (q_empty),
    .rd_ctl  (rd_ctl),
    .result  (result)
  );

endmodule

[src/hcbp_checker.sv]
// ----------------------------------------------------------------------------
// hcbp_checker
// Port-level checks on the Huffman code bit packer.
// ----------------------------------------------------------------------------
module hcbp_checker import hcbp_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              item_ready,
  input logic              result_valid,
  input logic              result_ready,
  input logic [BYTE_W-1:0] result_byte,
  input logic              result_last
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result valid dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> $stable(result_byte) && $stable(result_last))
    else $error("result payload changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

  a_reset_ready: assert property (@(posedge clk)
    $past(rst) |-> item_ready)
    else $error("item not ready right after reset");

endmodule

bind huffman_code_bit_packer_core hcbp_checker u_hcbp_checker (
  .clk          (clk),
  .rst          (rst),
  .item_ready   (item.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .result_byte  (result.out_byte),
  .result_last  (result.last)
);

[verif/hcbp_byte_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbp_byte_checker
// Watches both channels of the bit packer, predicts every packed byte from
// the accepted items and compares each result transfer with the oldest
// predicted byte. Reports the mismatch count and the bytes still awaited.
// ----------------------------------------------------------------------------
module hcbp_byte_checker import hcbp_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  hcbp_item_if   item,
  hcbp_result_if result,
  output int     mismatches,
  output int     bytes_awaited,
  output int     bytes_checked
);

  typedef struct {
    logic [BYTE_W-1:0] out_byte;
    logic              last;
  } packed_byte_t;

  logic [LEN_W-1:0]   len_table [SYMBOL_COUNT];
  logic [VALUE_W-1:0] code_table [SYMBOL_COUNT];
  logic [PEND_W-1:0]  held_bits;
  int                 held_count;
  packed_byte_t       byte_queue [$];

  task automatic pack_item(input logic [1:0] k, input logic [SYM_W-1:0] s,
                           input logic [VALUE_W-1:0] v, input logic [LEN_W-1:0] l);
    logic [ACC_W-1:0] acc;
    logic [LEN_W-1:0] clen;
    int               total;
    packed_byte_t     pb;
    if (k == KIND_LOAD) begin
      clen = (l > LEN_LIMIT) ? LEN_W'(LEN_LIMIT) : l;
      if (clen < VALUE_W) v = v & ((VALUE_W'(1) << clen) - VALUE_W'(1));
      len_table[s]  = clen;
      code_table[s] = v;
    end else if (k == KIND_ENCODE) begin
      clen = len_table[s];
      if (clen != 0) begin
        acc   = (ACC_W'(held_bits) << clen) | ACC_W'(code_table[s]);
        total = held_count + int'(clen);
        while (total >= BYTE_W) begin
          total       = total - BYTE_W;
          pb.out_byte = BYTE_W'(acc >> total);
          pb.last     = (total < BYTE_W);
          byte_queue.insert(byte_queue.size(), pb);
        end
        held_count = total;
        held_bits  = PEND_W'(acc) & ((PEND_W'(1) << total) - PEND_W'(1));
      end
    end else if (k == KIND_FLUSH) begin
      if (held_count != 0) begin
        pb.out_byte = BYTE_W'({1'b0, held_bits} << (BYTE_W - held_count));
        pb.last     = 1'b1;
        byte_queue.insert(byte_queue.size(), pb);
        held_bits  = '0;
        held_count = 0;
      end
    end
  endtask

  always @(posedge clk) begin
    packed_byte_t want;
    if (rst) begin
      for (int i = 0; i < SYMBOL_COUNT; i++) begin
        len_table[i]  = '0;
        code_table[i] = '0;
      end
      held_bits  = '0;
      held_count = 0;
      byte_queue.delete();
      mismatches    <= 0;
      bytes_checked <= 0;
    end else begin
      if (item.valid && item.ready)
        pack_item(item.kind, item.symbol, item.code_value, item.code_length);
      if (result.valid && result.ready) begin
        bytes_checked <= bytes_checked + 1;
        if (byte_queue.size() == 0) begin
          $error("unexpected result transfer: out_byte %0h last %0b",
                 result.out_byte, result.last);
          mismatches <= mismatches + 1;
        end else begin
          want = byte_queue.pop_front();
          if (result.out_byte !== want.out_byte || result.last !== want.last)
            mismatches <= mismatches + 1;
          if (result.out_byte !== want.out_byte)
            $error("out_byte: expected %0h, actual %0h", want.out_byte, result.out_byte);
          if (result.last !== want.last)
            $error("last: expected %0b, actual %0b", want.last, result.last);
        end
      end
    end
    bytes_awaited <= byte_queue.size();
  end

endmodule

[verif/tb_huffman_code_bit_packer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_huffman_code_bit_packer_core
// Drives load, encode and flush items into the bit packer with random gaps
// on both channels: a directed pass over length extremes, masking, unloaded
// symbols and empty flushes, then a long random stream of all item kinds.
// The byte checker beside the block judges every result.
// ----------------------------------------------------------------------------
module tb_huffman_code_bit_packer_core;
  import hcbp_pkg::*;

  localparam logic [1:0] KIND_UNUSED  = 2'd3;
  localparam int         RANDOM_ITEMS = 1250;
  localparam int         STALL_LIMIT  = 2000;

  logic clk;
  logic rst;
  logic calm;
  int   mismatches;
  int   bytes_awaited;
  int   bytes_checked;
  int   quiet_cycles;
  int   n_load, n_encode, n_flush, n_unused;
  logic [SYM_W-1:0] loaded_syms [$];

  hcbp_item_if   item_ch ();
  hcbp_result_if result_ch ();

  huffman_code_bit_packer_core u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  hcbp_byte_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .item          (item_ch),
    .result        (result_ch),
    .mismatches    (mismatches),
    .bytes_awaited (bytes_awaited),
    .bytes_checked (bytes_checked)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial result_ch.ready = 1'b0;
  always @(negedge clk) begin
    result_ch.ready <= rst ? 1'b0 : (calm || $urandom_range(99) >= 9);
  end

  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("tb_huffman_code_bit_packer_core: done, errors");
    $finish;
  end

  task automatic send_item(input logic [1:0] k, input logic [SYM_W-1:0] s,
                           input logic [VALUE_W-1:0] v, input logic [LEN_W-1:0] l);
    while (!calm && $urandom_range(99) < 9) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.valid       <= 1'b1;
    item_ch.kind        <= k;
    item_ch.symbol      <= s;
    item_ch.code_value  <= v;
    item_ch.code_length <= l;
    do @(posedge clk); while (!item_ch.ready);
    @(negedge clk);
    case (k)
      KIND_LOAD: begin
        n_load++;
        loaded_syms.insert(loaded_syms.size(), s);
      end
      KIND_ENCODE: n_encode++;
      KIND_FLUSH:  n_flush++;
      default:     n_unused++;
    endcase
  endtask

  initial begin
    int counted;
    int pick;
    logic [LEN_W-1:0] len;
    logic [SYM_W-1:0] sym;
    counted  = 0;
    n_load   = 0;
    n_encode = 0;
    n_flush  = 0;
    n_unused = 0;
    calm     = 1'b0;
    rst      = 1'b1;
    item_ch.valid       = 1'b0;
    item_ch.kind        = KIND_LOAD;
    item_ch.symbol      = '0;
    item_ch.code_value  = '0;
    item_ch.code_length = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_item(KIND_ENCODE, 8'h00, 16'hFFFF, 5'd31);
    send_item(KIND_FLUSH,  8'hFF, 16'h0000, 5'd0);
    send_item(KIND_UNUSED, 8'hA5, 16'hFFFF, 5'd31);
    send_item(KIND_LOAD,   8'hFF, 16'hFFFF, 5'd16);
    send_item(KIND_LOAD,   8'h00, 16'h0000, 5'd1);
    send_item(KIND_LOAD,   8'h01, 16'hA5C3, 5'd20);
    send_item(KIND_LOAD,   8'h02, 16'hFFFF, 5'd3);
    send_item(KIND_LOAD,   8'h03, 16'h1234, 5'd0);
    send_item(KIND_LOAD,   8'h80, 16'h0000, 5'd31);
    send_item(KIND_LOAD,   8'h04, 16'h0055, 5'd7);
    send_item(KIND_LOAD,   8'h05, 16'hFFAA, 5'd8);
    send_item(KIND_ENCODE, 8'hFF, 16'h0000, 5'd0);
    send_item(KIND_ENCODE, 8'h00, 16'h0000, 5'd0);
    send_item(KIND_ENCODE, 8'hFF, 16'h0000, 5'd0);
    send_item(KIND_ENCODE, 8'h04, 16'h0000, 5'd0);
    send_item(KIND_ENCODE, 8'h05, 16'h0000, 5'd0);
    send_item(KIND_ENCODE, 8'h02, 16'h0000, 5'd0);
    send_item(KIND_ENCODE, 8'h01, 16'h0000, 5'd0);
    send_item(KIND_ENCODE, 8'h03, 16'h0000, 5'd0);
    send_item(KIND_FLUSH,  8'h00, 16'h0000, 5'd0);
    send_item(KIND_FLUSH,  8'h00, 16'h0000, 5'd0);
    send_item(KIND_ENCODE, 8'h80, 16'h0000, 5'd0);
    send_item(KIND_UNUSED, 8'h02, 16'h0000, 5'd0);
    send_item(KIND_ENCODE, 8'h80, 16'h0000, 5'd0);
    send_item(KIND_FLUSH,  8'h00, 16'h0000, 5'd0);

    while (counted < RANDOM_ITEMS) begin
      calm = (counted >= 400 && counted < 650);
      pick = $urandom_range(99);
      if (pick < 15) begin
        len = ($urandom_range(9) == 0) ? LEN_W'($urandom_range(31))
                                       : LEN_W'($urandom_range(16, 1));
        send_item(KIND_LOAD, SYM_W'($urandom_range(255)), VALUE_W'($urandom), len);
        counted++;
      end else if (pick < 85) begin
        if (loaded_syms.size() != 0 && $urandom_range(3) != 0)
          sym = loaded_syms[$urandom_range(loaded_syms.size() - 1)];
        else
          sym = SYM_W'($urandom_range(255));
        send_item(KIND_ENCODE, sym, VALUE_W'($urandom), LEN_W'($urandom));
        counted++;
      end else if (pick < 95) begin
        send_item(KIND_FLUSH, SYM_W'($urandom), VALUE_W'($urandom), LEN_W'($urandom));
        counted++;
      end else begin
        send_item(KIND_UNUSED, SYM_W'($urandom), VALUE_W'($urandom), LEN_W'($urandom));
        counted++;
      end
    end
    calm = 1'b0;
    item_ch.valid <= 1'b0;

    // drain
    while (bytes_awaited != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d loads, %0d encodes, %0d flushes, %0d ignored items",
             n_load, n_encode, n_flush, n_unused);
    $display("checked %0d packed bytes, %0d mismatching", bytes_checked, mismatches);
    if (mismatches == 0 && bytes_awaited == 0)
      $display("tb_huffman_code_bit_packer_core: done, clean");
    else
      $display("tb_huffman_code_bit_packer_core: done, errors");
    $finish;
  end

endmodule

[huffman_code_bit_packer_core.f]
src/hcbp_pkg.sv
src/hcbp_if.sv
src/hcbp_front.sv
src/hcbp_queue.sv
src/hcbp_back.sv
src/huffman_code_bit_packer_core.sv
src/hcbp_checker.sv
verif/hcbp_byte_checker.sv
verif/tb_huffman_code_bit_packer_core.sv
